### design/lpg_pkg.sv
// Shared types and constants for the line pixel generator.
`timescale 1ns / 1ps

package lpg_pkg;

    // Field widths of the request and pixel words.
    localparam int COORD_W = 6;
    localparam int COLOR_W = 32;

    // Error accumulator width: holds values below four times the major delta.
    localparam int ERR_W = COORD_W + 2;

    // Default canvas edge length.
    localparam int CANVAS_SIZE_DEF = 64;

    // One line request.
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COLOR_W-1:0] line_color;
    } t_line_req;

    // One emitted pixel.
    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
    } t_pixel;

    // Control from the sequencer to the stepping unit.
    typedef struct packed {
        logic               load;
        logic               step;
        logic [COORD_W-1:0] dmaj;
        logic [COORD_W-1:0] dmin;
    } t_dda_ctl;

    // Status from the stepping unit back to the sequencer.
    typedef struct packed {
        logic [COORD_W-1:0] k;
        logic [COORD_W-1:0] k_next;
        logic [COORD_W-1:0] q;
        logic [COORD_W-1:0] q_next;
        logic               at_end;
    } t_dda_stat;

endpackage

### design/lpg_dda_unit.sv
// Error accumulator that steps the major count and rounded minor offset.
`timescale 1ns / 1ps

module lpg_dda_unit (
    input  logic                i_clk,
    input  lpg_pkg::t_dda_ctl   i_ctl,
    output lpg_pkg::t_dda_stat  o_stat
);
    import lpg_pkg::*;

    logic [COORD_W-1:0] r_k, n_k;
    logic [COORD_W-1:0] r_q, n_q;
    logic [ERR_W-1:0]   r_e, n_e;
    logic [COORD_W-1:0] r_dmaj;
    logic [COORD_W-1:0] r_dmin;

    logic [ERR_W-1:0]   w_sum;
    logic [ERR_W-1:0]   w_two_maj;
    logic               w_carry;

    // The remainder tracks (2*k*dmin + dmaj) mod (2*dmaj); one add and
    // one compare per step, and the offset rises by at most one.
    always_comb begin
        w_sum     = r_e + ERR_W'({r_dmin, 1'b0});
        w_two_maj = ERR_W'({r_dmaj, 1'b0});
        w_carry   = (w_sum >= w_two_maj);
        n_e       = w_carry ? (w_sum - w_two_maj) : w_sum;
        n_q       = r_q + COORD_W'(w_carry);
        n_k       = r_k + COORD_W'(1);
    end

    // Load starts a new line at step zero with the half-step bias.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_k    <= '0;
            r_q    <= '0;
            r_e    <= ERR_W'(i_ctl.dmaj);
            r_dmaj <= i_ctl.dmaj;
            r_dmin <= i_ctl.dmin;
        end else if (i_ctl.step) begin
            r_k <= n_k;
            r_q <= n_q;
            r_e <= n_e;
        end
    end

    assign o_stat.k      = r_k;
    assign o_stat.k_next = n_k;
    assign o_stat.q      = r_q;
    assign o_stat.q_next = n_q;
    assign o_stat.at_end = (r_k == r_dmaj);

endmodule

### design/line_pixel_generator.sv
// Top level of the line pixel generator: request setup, sequencer and pixel output.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. The block then
// stays busy while one error accumulator advances the line by one major
// step per cycle up to its end point (on a smaller canvas it stops after
// the last pixel on the canvas). Each pixel appears on o_pixel for one
// cycle with o_valid high, in the cycle after its step, in order of rising
// major coordinate, and last marks the final pixel. The receiver cannot
// stall the output, so it must take every pixel in the cycle it is shown.
// Pixels off a canvas smaller than 64 are dropped, and a line entirely off
// the canvas gives no pixel.
module line_pixel_generator #(
    parameter int CANVAS_SIZE = lpg_pkg::CANVAS_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  lpg_pkg::t_line_req i_req,
    output logic               busy,
    output logic               o_valid,
    output lpg_pkg::t_pixel    o_pixel
);
    import lpg_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic               r_state, n_state;
    logic               r_xmajor;
    logic               r_min_neg;
    logic [COORD_W-1:0] r_bmaj;
    logic [COORD_W-1:0] r_bmin;
    logic [COLOR_W-1:0] r_color;
    logic               r_out_vld, n_out_vld;
    t_pixel             r_out, n_out;

    logic               w_accept;
    logic [COORD_W:0]   w_dx, w_dy;
    logic [COORD_W-1:0] w_adx, w_ady;
    logic               w_xmajor, w_swap, w_min_neg, w_minor_neg, w_minor_pos;
    logic [COORD_W-1:0] w_bx, w_by;

    logic [COORD_W-1:0] w_cur_min, w_nxt_min, w_cur_maj, w_nxt_maj;
    logic               w_cur_ok, w_nxt_ok, w_finish;

    t_dda_ctl           w_ctl;
    t_dda_stat          w_stat;

    assign w_accept = start && !busy;
    assign busy     = (r_state == ST_RUN);

    // Request setup: deltas, major axis, and endpoint order.
    always_comb begin
        w_dx        = {1'b0, i_req.end_x} - {1'b0, i_req.start_x};
        w_dy        = {1'b0, i_req.end_y} - {1'b0, i_req.start_y};
        w_adx       = w_dx[COORD_W] ? COORD_W'(-w_dx) : w_dx[COORD_W-1:0];
        w_ady       = w_dy[COORD_W] ? COORD_W'(-w_dy) : w_dy[COORD_W-1:0];
        w_xmajor    = (w_adx >= w_ady);
        w_swap      = w_xmajor ? w_dx[COORD_W] : w_dy[COORD_W];
        w_minor_neg = w_xmajor ? w_dy[COORD_W] : w_dx[COORD_W];
        w_minor_pos = !w_minor_neg && ((w_xmajor ? w_ady : w_adx) != '0);
        w_min_neg   = w_swap ? w_minor_pos : w_minor_neg;
        w_bx        = w_swap ? i_req.end_x : i_req.start_x;
        w_by        = w_swap ? i_req.end_y : i_req.start_y;
    end

    // Control for the stepping unit.
    always_comb begin
        w_ctl.load = w_accept;
        w_ctl.step = (r_state == ST_RUN);
        w_ctl.dmaj = w_xmajor ? w_adx : w_ady;
        w_ctl.dmin = w_xmajor ? w_ady : w_adx;
    end

    lpg_dda_unit u_dda (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_stat (w_stat)
    );

    // Current and next pixel positions and their canvas checks; the pixels
    // on the canvas form one unbroken run, so the next check finds the last.
    always_comb begin
        w_cur_maj = r_bmaj + w_stat.k;
        w_nxt_maj = r_bmaj + w_stat.k_next;
        w_cur_min = r_min_neg ? (r_bmin - w_stat.q) : (r_bmin + w_stat.q);
        w_nxt_min = r_min_neg ? (r_bmin - w_stat.q_next) : (r_bmin + w_stat.q_next);
        w_cur_ok  = (32'(w_cur_maj) < CANVAS_SIZE) && (32'(w_cur_min) < CANVAS_SIZE);
        w_nxt_ok  = (32'(w_nxt_maj) < CANVAS_SIZE) && (32'(w_nxt_min) < CANVAS_SIZE);
        w_finish  = w_stat.at_end || (w_cur_ok && !w_nxt_ok);
    end

    // Sequencer and output register.
    always_comb begin
        n_state   = r_state;
        n_out_vld = 1'b0;
        n_out     = r_out;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_out_vld         = w_cur_ok;
                n_out.pixel_x     = r_xmajor ? w_cur_maj : w_cur_min;
                n_out.pixel_y     = r_xmajor ? w_cur_min : w_cur_maj;
                n_out.pixel_color = r_color;
                n_out.last        = w_stat.at_end || !w_nxt_ok;
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers: the output pixel is loaded every cycle, the line setup when a request is taken.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_accept) begin
            r_xmajor  <= w_xmajor;
            r_min_neg <= w_min_neg;
            r_bmaj    <= w_xmajor ? w_bx : w_by;
            r_bmin    <= w_xmajor ? w_by : w_bx;
            r_color   <= i_req.line_color;
        end
    end

    assign o_valid = r_out_vld;
    assign o_pixel = r_out;

    // A pixel only follows a cycle of line stepping.
    a_valid_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_RUN))
        else $error("pixel strobe without a preceding step");

    // The final pixel of a line is never directly followed by another.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pixel.last) |=> !o_valid)
        else $error("pixel strobe right after the last pixel");

    // A taken request makes the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("not busy after a request was taken");

endmodule
